/* sv/cpc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_pkg
// shared types, constants and helpers of the contact correction block
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SHARE_BITS    = 16;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [16:0] FRAC_RESET = 17'd52429;
    localparam logic [30:0] SLOP_RESET = 31'd655;

    // register index codes
    localparam logic REG_FRAC = 1'b0;
    localparam logic REG_SLOP = 1'b1;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] depth;
        logic               kind_a;
        logic               kind_b;
        logic [30:0]        mass_a;
        logic [30:0]        mass_b;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] offset_a_x;
        logic signed [31:0] offset_a_y;
        logic signed [31:0] offset_a_z;
        logic signed [31:0] offset_b_x;
        logic signed [31:0] offset_b_y;
        logic signed [31:0] offset_b_z;
        logic               bad_mass;
    } t_out_req;

    // classified contact, slop already removed
    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic [30:0]        d;
        logic               kind_a;
        logic               kind_b;
        logic [30:0]        mass_a;
        logic [30:0]        mass_b;
    } t_contact;

    // what rides along the share divider
    typedef struct packed {
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
        logic               kind_a;
        logic               kind_b;
        logic               bad;
    } t_div_pay;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic valid;
    } t_queue_stat;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sh0000_0000_7fff_ffff) begin
            r = 32'h7fff_ffff;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/cpc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_front
// input register, slop removal and push into the queue
// ----------------------------------------------------------------------------
module cpc_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire cpc_pkg::t_in_req i_data,
    input  wire logic [30:0]      i_slop,
    input  wire cpc_pkg::t_queue_stat i_stat,
    output logic                  o_push,
    output cpc_pkg::t_contact     o_entry
);
    import cpc_pkg::*;

    logic               r_valid;
    t_contact           r_entry;
    logic signed [32:0] diff;
    t_contact           n_entry;

    assign o_push  = r_valid && !i_stat.full;
    assign o_ready = !r_valid || !i_stat.full;
    assign o_entry = r_entry;

    always_comb begin
        diff = {i_data.depth[31], i_data.depth} - $signed({2'b00, i_slop});
        n_entry.normal_x = i_data.normal_x;
        n_entry.normal_y = i_data.normal_y;
        n_entry.normal_z = i_data.normal_z;
        n_entry.d        = diff[32] ? 31'd0 : diff[30:0];
        n_entry.kind_a   = i_data.kind_a;
        n_entry.kind_b   = i_data.kind_b;
        n_entry.mass_a   = i_data.mass_a;
        n_entry.mass_b   = i_data.mass_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_entry <= n_entry;
        end
    end

endmodule
`default_nettype wire

/* sv/cpc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module cpc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire cpc_pkg::t_contact i_entry,
    input  wire logic              i_pop,
    output cpc_pkg::t_contact      o_head,
    output cpc_pkg::t_queue_stat   o_stat
);
    import cpc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_contact        r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;

    assign o_stat.full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_stat.valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

/* sv/cpc_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_div
// pipelined restoring divider for the mass share, one quotient bit per stage
// ----------------------------------------------------------------------------
module cpc_div #(
    parameter int PAY_W = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [30:0]        i_num,
    input  wire logic [31:0]        i_den,
    input  wire logic [PAY_W-1:0]   i_pay,
    output logic                    o_valid,
    output logic [cpc_pkg::SHARE_BITS:0] o_quo,
    output logic [PAY_W-1:0]        o_pay
);
    import cpc_pkg::*;

    localparam int QW = SHARE_BITS + 1;

    logic             r_v   [QW];
    logic [31:0]      r_rem [QW];
    logic [31:0]      r_den [QW];
    logic [QW-1:0]    r_q   [QW];
    logic [PAY_W-1:0] r_pay [QW];

    logic [31:0]      n_rem [QW];
    logic [QW-1:0]    n_q   [QW];

    always_comb begin
        logic [32:0] t;
        logic        ge;
        // top bit: numerator against denominator directly
        ge = ({1'b0, i_num} >= i_den);
        n_rem[0] = ge ? ({1'b0, i_num} - i_den) : {1'b0, i_num};
        n_q[0]   = '0;
        n_q[0][QW-1] = ge;
        for (int k = 1; k < QW; k++) begin
            t  = {r_rem[k-1], 1'b0};
            ge = (t >= {1'b0, r_den[k-1]});
            n_rem[k] = ge ? 32'(t - {1'b0, r_den[k-1]}) : t[31:0];
            n_q[k]   = r_q[k-1];
            n_q[k][QW-1-k] = ge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < QW; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_den[0] <= i_den;
            r_q[0]   <= n_q[0];
            r_pay[0] <= i_pay;
            for (int k = 1; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= n_q[k];
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_q[QW-1];
    assign o_pay   = r_pay[QW-1];

endmodule
`default_nettype wire

/* sv/cpc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_back
// magnitude, correction vector, mass split and output register
// ----------------------------------------------------------------------------
module cpc_back #(
    parameter int FRAC_BITS = cpc_pkg::FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cpc_pkg::t_queue_stat i_stat,
    input  wire cpc_pkg::t_contact i_head,
    output logic                   o_pop,
    input  wire logic [16:0]       i_frac,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output cpc_pkg::t_out_req      o_data
);
    import cpc_pkg::*;

    localparam int PAY_W = $bits(t_div_pay);

    logic en;

    // stage 1
    logic               r_s1_v;
    logic [30:0]        r_mag;
    logic signed [31:0] r_n [3];
    logic               r_s1_ka, r_s1_kb;
    logic [30:0]        r_s1_mb;
    logic [31:0]        r_s1_sum;
    logic [47:0]        prod_m;
    logic [30:0]        n_mag;

    // stage 2
    logic               r_s2_v;
    t_div_pay           r_s2_pay;
    logic [30:0]        r_s2_mb;
    logic [31:0]        r_s2_sum;
    t_div_pay           n_s2_pay;
    logic signed [63:0] pn [3];

    // divider output
    logic               dv_v;
    logic [SHARE_BITS:0] dv_q;
    logic [PAY_W-1:0]   dv_raw;
    t_div_pay           dv_pay;

    logic               r_out_v;
    t_out_req           r_out;
    t_out_req           n_out;

    assign en    = !r_out_v || i_ready;
    assign o_pop = en && i_stat.valid;

    always_comb begin
        prod_m = 48'(i_head.d) * 48'(i_frac);
        n_mag  = prod_m[47] ? 31'h7fff_ffff : prod_m[46:16];
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pn[i] = 64'(r_n[i]) * 64'($signed({1'b0, r_mag}));
        end
        n_s2_pay.c_x    = sat32(pn[0] >>> FRAC_BITS);
        n_s2_pay.c_y    = sat32(pn[1] >>> FRAC_BITS);
        n_s2_pay.c_z    = sat32(pn[2] >>> FRAC_BITS);
        n_s2_pay.kind_a = r_s1_ka;
        n_s2_pay.kind_b = r_s1_kb;
        n_s2_pay.bad    = !r_s1_ka && !r_s1_kb && (r_s1_sum == 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s1_v  <= o_pop;
            r_s2_v  <= r_s1_v;
            r_out_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag    <= n_mag;
            r_n[0]   <= i_head.normal_x;
            r_n[1]   <= i_head.normal_y;
            r_n[2]   <= i_head.normal_z;
            r_s1_ka  <= i_head.kind_a;
            r_s1_kb  <= i_head.kind_b;
            r_s1_mb  <= i_head.mass_b;
            r_s1_sum <= 32'(i_head.mass_a) + 32'(i_head.mass_b);
            r_s2_pay <= n_s2_pay;
            r_s2_mb  <= r_s1_mb;
            r_s2_sum <= r_s1_sum;
            r_out    <= n_out;
        end
    end

    cpc_div #(
        .PAY_W (PAY_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_v),
        .i_num   (r_s2_mb),
        .i_den   (r_s2_sum),
        .i_pay   (r_s2_pay),
        .o_valid (dv_v),
        .o_quo   (dv_q),
        .o_pay   (dv_raw)
    );

    assign dv_pay = t_div_pay'(dv_raw);

    always_comb begin
        logic signed [31:0] c [3];
        logic signed [17:0] sb;
        logic signed [49:0] pa, pb;
        pa   = '0;
        pb   = '0;
        c[0] = dv_pay.c_x;
        c[1] = dv_pay.c_y;
        c[2] = dv_pay.c_z;
        sb   = $signed({1'b0, dv_q}) - 18'sd65536;
        n_out = '0;
        n_out.bad_mass = dv_pay.bad;
        if (dv_pay.bad) begin
            n_out.bad_mass = 1'b1;
        end else if (!dv_pay.kind_a && !dv_pay.kind_b) begin
            pa = 50'(c[0]) * 50'($signed({1'b0, dv_q}));
            pb = 50'(c[0]) * 50'(sb);
            n_out.offset_a_x = sat32(64'(pa >>> SHARE_BITS));
            n_out.offset_b_x = sat32(64'(pb >>> SHARE_BITS));
            pa = 50'(c[1]) * 50'($signed({1'b0, dv_q}));
            pb = 50'(c[1]) * 50'(sb);
            n_out.offset_a_y = sat32(64'(pa >>> SHARE_BITS));
            n_out.offset_b_y = sat32(64'(pb >>> SHARE_BITS));
            pa = 50'(c[2]) * 50'($signed({1'b0, dv_q}));
            pb = 50'(c[2]) * 50'(sb);
            n_out.offset_a_z = sat32(64'(pa >>> SHARE_BITS));
            n_out.offset_b_z = sat32(64'(pb >>> SHARE_BITS));
        end else if (!dv_pay.kind_a && dv_pay.kind_b) begin
            n_out.offset_a_x = c[0];
            n_out.offset_a_y = c[1];
            n_out.offset_a_z = c[2];
        end else if (dv_pay.kind_a && !dv_pay.kind_b) begin
            n_out.offset_b_x = sat32(-64'(c[0]));
            n_out.offset_b_y = sat32(-64'(c[1]));
            n_out.offset_b_z = sat32(-64'(c[2]));
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule
`default_nettype wire

/* sv/contact_penetration_correction.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// contact_penetration_correction
// position correction offsets for one contact between two bodies
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_ready carry one contact request
//   (normal, depth, body kinds, masses); output channel: o_out_valid /
//   i_out_ready carry the six offsets and the bad-mass flag
//   apb port: register 0 at 0x0 is the correction fraction, register 1 at
//   0x4 is the depth slop; write only while no request is in flight
//   throughput: one request per cycle while i_out_ready is held high, set by
//   the fully pipelined back end (one multiplier level per stage, share
//   divider one bit per stage); path from acceptance to o_out_valid:
//   input register, queue, two multiply stages, 17 divider stages, output
//   when the receiver stalls, the back end freezes as a whole; the 4-entry
//   queue and the front register keep taking requests until they fill
//   reset: synchronous active low, empties every stage, registers go to
//   fraction 52429 (about 0.8) and slop 655 (about 0.01)
// ----------------------------------------------------------------------------
module contact_penetration_correction #(
    parameter int FRAC_BITS = cpc_pkg::FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire cpc_pkg::t_in_req  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output cpc_pkg::t_out_req      o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import cpc_pkg::*;

    // configuration registers
    logic [16:0] r_frac;
    logic [30:0] r_slop;
    logic        cfg_wr;

    // front to queue
    logic        push;
    t_contact    entry;
    t_queue_stat qstat;

    // queue to back
    t_contact    head;
    logic        pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= FRAC_RESET;
            r_slop <= SLOP_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FRAC: r_frac <= pwdata[16:0];
                REG_SLOP: r_slop <= pwdata[30:0];
                default:  ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[2])
            REG_FRAC: prdata = {15'd0, r_frac};
            REG_SLOP: prdata = {1'b0, r_slop};
            default:  prdata = '0;
        endcase
    end

    // front: take the request, strip slop, clamp at zero
    cpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .i_slop  (r_slop),
        .i_stat  (qstat),
        .o_push  (push),
        .o_entry (entry)
    );

    // decoupling queue
    cpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    // back: magnitude, correction vector, mass split, output register
    cpc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (qstat),
        .i_head  (head),
        .o_pop   (pop),
        .i_frac  (r_frac),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire
